@@ hw/rtl/rcsfd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_pkg: shared definitions for the RC serial frame decoder
// Frame and channel sizes, register codes, reset values and the queue word.
// ----------------------------------------------------------------------------
package rcsfd_pkg;

    localparam int FRAME_BYTES  = 16;
    localparam int MAX_CHANNELS = 8;

    // Write slot index and number of 2-byte channel words in one frame.
    localparam int POS_W    = $clog2(FRAME_BYTES);
    localparam int NWORDS   = (FRAME_BYTES - 2) / 2;
    localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W    = 5;

    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int CHAN_W    = 4;
    localparam int VALUE_W   = 11;
    localparam int PULSE_W   = 11;
    localparam int GAP_W     = 16;

    localparam logic [PULSE_W-1:0] PULSE_BASE = PULSE_W'(988);
    localparam logic [PULSE_W-1:0] PULSE_IDLE = PULSE_W'(1500);

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_HI_RES    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT = 1'b1;
    localparam logic             HI_RES_RESET    = 1'b1;
    localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = GAP_W'(5000);

    // Word kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic              is_read;
        logic [BYTE_W-1:0] data_byte;
        logic [TIME_W-1:0] time_us;
        logic [CHAN_W-1:0] channel;
    } t_item;

    // Number of channels the current mode carries, capped at MAX_CHANNELS.
    function automatic logic [CNT_W-1:0] chan_count(input logic hi_res);
        logic [CNT_W-1:0] n;
        n = hi_res ? CNT_W'(8) : CNT_W'(7);
        if (n > CNT_W'(MAX_CHANNELS)) begin
            n = CNT_W'(MAX_CHANNELS);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/rc_serial_frame_decoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_unit: RC serial receiver frame decoder
// Builds 16-byte frames from timestamped serial bytes and answers channel
// pulse-width reads from the decoded channel values.
// ----------------------------------------------------------------------------
// The input channel carries one word per handshake: either a received serial
// byte with its microsecond timestamp, or a read request for one channel.
// A byte word produces no result. A read word produces exactly one result word
// on the output channel: the channel pulse width and a flag that tells whether
// this read decoded a newly completed frame.
// The front stage accepts up to one word per cycle into a four-entry queue
// while it has room. The back stage retires one queued word per cycle: byte
// words always, read words whenever the result register is empty or is
// being taken. A read word passes through the queue and then the result
// register. Sustained throughput is one word per clock when no result is
// stalled, set by the combinational frame decode and add in the back stage.
// When the receiver stalls, the result register holds its word, byte words
// keep draining until a read word reaches the queue head, and the queue
// absorbs up to four words before o_in_stall rises. Reset is synchronous and
// active low: the queue empties, the frame position and timestamp clear, the
// channel store reads zero, hi_res returns to 1 and the gap limit to 5000 us.
// Configuration writes must go in when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rc_serial_frame_decoder_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rcsfd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [rcsfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_kind,
    input  wire logic [rcsfd_pkg::BYTE_W-1:0]       i_data_byte,
    input  wire logic [rcsfd_pkg::TIME_W-1:0]       i_time_us,
    input  wire logic [rcsfd_pkg::CHAN_W-1:0]       i_channel,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [rcsfd_pkg::PULSE_W-1:0]           o_pulse_us,
    output logic                                    o_frame_decoded
);
    import rcsfd_pkg::*;

    // Queue head as seen by the back stage, and its retire strobe.
    t_item head;
    logic  head_valid;
    logic  pop;

    rcsfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_time_us    (i_time_us),
        .i_channel    (i_channel),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    rcsfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_head          (head),
        .i_head_valid    (head_valid),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pulse_us      (o_pulse_us),
        .o_frame_decoded (o_frame_decoded)
    );

endmodule
`default_nettype wire

@@ hw/rtl/rcsfd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_front: input stage and word queue
// Accepts input words, tags each as a byte or a read, and queues it.
// ----------------------------------------------------------------------------
module rcsfd_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_kind,
    input  wire logic [rcsfd_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [rcsfd_pkg::TIME_W-1:0]   i_time_us,
    input  wire logic [rcsfd_pkg::CHAN_W-1:0]   i_channel,
    output rcsfd_pkg::t_item                    o_head,
    output logic                                o_head_valid,
    input  wire logic                           i_pop
);
    import rcsfd_pkg::*;

    t_item              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]    r_count,  n_count;
    logic               push;
    logic               pop;
    t_item              in_item;

    assign o_in_stall   = (r_count == (QPTR_W+1)'(QDEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        in_item.is_read   = (i_kind == KIND_READ);
        in_item.data_byte = i_data_byte;
        in_item.time_us   = i_time_us;
        in_item.channel   = i_channel;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/rcsfd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_back: frame assembly, channel decode and result register
// Executes one word per cycle; a read waits while the held result stalls.
// ----------------------------------------------------------------------------
module rcsfd_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rcsfd_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [rcsfd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire rcsfd_pkg::t_item                   i_head,
    input  wire logic                               i_head_valid,
    output logic                                    o_pop,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [rcsfd_pkg::PULSE_W-1:0]           o_pulse_us,
    output logic                                    o_frame_decoded
);
    import rcsfd_pkg::*;

    logic                r_hi_res;
    logic [GAP_W-1:0]    r_gap_limit;
    logic [BYTE_W-1:0]   r_bytes [FRAME_BYTES];
    logic [POS_W-1:0]    r_pos;
    logic [TIME_W-1:0]   r_last_time;
    logic                r_complete;
    logic                r_seen;
    logic [VALUE_W-1:0]  r_values [MAX_CHANNELS];
    logic                r_out_valid;
    logic [PULSE_W-1:0]  r_pulse,   n_pulse;
    logic                r_decoded;

    logic                out_free;
    logic                do_byte;
    logic                do_read;
    logic [TIME_W-1:0]   gap;
    logic [POS_W-1:0]    slot;
    logic [CNT_W-1:0]    cnt;
    logic [VALUE_W-1:0]  dec_values [MAX_CHANNELS];
    logic [VALUE_W-1:0]  rd_value;
    logic [PULSE_W:0]    sum;
    logic                in_range;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_head_valid && (!i_head.is_read || out_free);
    assign do_byte  = o_pop && !i_head.is_read;
    assign do_read  = o_pop && i_head.is_read;
    assign cnt      = chan_count(r_hi_res);

    // A word gap longer than the limit starts a new frame.
    assign gap  = i_head.time_us - r_last_time;
    assign slot = (gap > TIME_W'(r_gap_limit)) ? '0 : r_pos;

    // Decode all words of the held frame; a later word for the same id wins.
    always_comb begin
        logic [BYTE_W-1:0]  hi;
        logic [BYTE_W-1:0]  lo;
        logic [3:0]         id;
        logic [VALUE_W-1:0] val;
        dec_values = r_values;
        for (int w = 0; w < NWORDS; w++) begin
            hi  = r_bytes[2*w + 2];
            lo  = r_bytes[2*w + 3];
            id  = r_hi_res ? hi[6:3] : hi[5:2];
            val = r_hi_res ? {hi[2:0], lo} : {1'b0, hi[1:0], lo};
            if ({1'b0, id} < cnt) begin
                dec_values[id[CH_IDX_W-1:0]] = val;
            end
        end
    end

    always_comb begin
        in_range = ({1'b0, i_head.channel} < cnt) && r_seen;
        rd_value = r_complete ? dec_values[i_head.channel[CH_IDX_W-1:0]]
                              : r_values[i_head.channel[CH_IDX_W-1:0]];
        if (r_hi_res) begin
            sum = (PULSE_W+1)'(PULSE_BASE) + (PULSE_W+1)'(rd_value >> 1);
        end else begin
            sum = (PULSE_W+1)'(PULSE_BASE) + (PULSE_W+1)'(rd_value);
        end
        n_pulse = in_range ? sum[PULSE_W-1:0] : PULSE_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_res    <= HI_RES_RESET;
            r_gap_limit <= GAP_LIMIT_RESET;
            r_pos       <= '0;
            r_last_time <= '0;
            r_complete  <= 1'b0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_values[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_HI_RES:    r_hi_res    <= i_cfg_data[0];
                    CFG_GAP_LIMIT: r_gap_limit <= i_cfg_data[GAP_W-1:0];
                endcase
            end
            if (do_byte) begin
                r_seen      <= 1'b1;
                r_last_time <= i_head.time_us;
                if (slot == LAST_POS) begin
                    r_complete <= 1'b1;
                    r_pos      <= slot;
                end else begin
                    r_pos <= slot + 1'b1;
                end
            end
            if (do_read && r_complete) begin
                r_complete <= 1'b0;
                r_values   <= dec_values;
            end
            if (do_read) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_byte) begin
            r_bytes[slot] <= i_head.data_byte;
        end
        if (do_read) begin
            r_pulse   <= n_pulse;
            r_decoded <= r_complete;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pulse_us      = r_pulse;
    assign o_frame_decoded = r_decoded;

endmodule
`default_nettype wire

@@ hw/rtl/rcsfd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcsfd_checker: port-level checks for the frame decoder
// Watches the top-level ports and is bound to every instance of the top level.
// ----------------------------------------------------------------------------
module rcsfd_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                o_in_stall,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_stall,
    input wire logic [rcsfd_pkg::PULSE_W-1:0]       o_pulse_us,
    input wire logic                                o_frame_decoded
);
    import rcsfd_pkg::*;

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pulse_us) && $stable(o_frame_decoded))
        else $error("result word changed while stalled");

    // Nothing is presented in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    // The queue can only fill up on a cycle that accepted a word.
    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall rose without an accepted word");

endmodule

bind rc_serial_frame_decoder_unit rcsfd_checker u_rcsfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pulse_us      (o_pulse_us),
    .o_frame_decoded (o_frame_decoded)
);
`default_nettype wire
